### rtl/quadrature_menu_position_assert.svh
// ============================================================================
// Assertion macros for the quadrature menu position block
// Shared helpers for the concurrent checks at the end of the RTL modules.
// ============================================================================
`ifndef QUADRATURE_MENU_POSITION_ASSERT_SVH
`define QUADRATURE_MENU_POSITION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define QMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qmp assertion failed");

// Next-cycle implication, checked on every rising edge outside of reset.
`define QMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qmp assertion failed");

`endif

### rtl/qmp_pkg.sv
// ============================================================================
// qmp_pkg
// Types, register indexes and the quadrature step table of the menu
// position tracker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package qmp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEPS_PER_DETENT = 2'd0;
    localparam logic [1:0] CFG_ITEM_COUNT       = 2'd1;
    localparam logic [1:0] CFG_VISIBLE_LINES    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [3:0] SPD_RESET   = 4'd4;
    localparam logic [7:0] COUNT_RESET = 8'd6;
    localparam logic [5:0] VIS_RESET   = 6'd5;

    // Lines idle high after reset.
    localparam logic [1:0] PHASE_IDLE = 2'b11;

    // Largest usable steps-per-detent value.
    localparam logic [3:0] SPD_MAX = 4'd8;

    // One result beat, position in the lowest bits.
    typedef struct packed {
        logic signed [1:0] detent_move;
        logic signed [1:0] micro_step;
        logic [7:0]        window_first;
        logic [7:0]        position;
    } qmp_result_t;

    // Quadrature step for {previous phase, new phase}; invalid moves give 0.
    function automatic logic signed [1:0] qmp_step(input logic [3:0] idx);
        logic signed [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/quadrature_menu_position.sv
// A sample's result is registered at the edge that accepts it and shows on m_tdata
// after that edge at the earliest. Throughput: one sample per cycle until the skid
// entry fills; the step table, detent accumulator, clamp and window update all settle
// combinationally between the state and result registers.
// A two-entry output stage lets one more sample in while a result is stalled.
// Reset (aresetn low, synchronous) restores the registers and state, empties the output.
// ============================================================================
// quadrature_menu_position
// Decodes encoder phase samples into detent moves of a clamped menu position
// and keeps a scroll window around that position.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "quadrature_menu_position_assert.svh"

module quadrature_menu_position
    import qmp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // Sample stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [1:0] phase_ab, [7:2] zero
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [7:0] position, [15:8] window_first,
                                        // [17:16] micro_step, [19:18] detent_move,
                                        // [23:20] zero
);

    // Configuration registers.
    logic [3:0] spd_reg;
    logic [7:0] count_reg;
    logic [5:0] vis_reg;

    // Tracker state.
    logic [1:0]        last_phase_reg;
    logic signed [3:0] accum_reg;
    logic [7:0]        pos_reg;
    logic [7:0]        ws_reg;

    // Output stage.
    qmp_result_t out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    // Datapath signals.
    logic [3:0]        spd_eff;
    logic [7:0]        cnt_eff;
    logic [5:0]        vis_eff;
    logic [1:0]        phase_now;
    logic signed [1:0] step;
    logic signed [4:0] acc_sum;
    logic signed [4:0] spd_s;
    logic signed [3:0] accum_next;
    logic signed [1:0] move;
    logic [8:0]        pos_inc;
    logic [7:0]        cnt_m1;
    logic [7:0]        pos_next;
    logic [8:0]        ws_limit;
    logic [7:0]        ws_next;
    qmp_result_t       result;
    logic              accept;
    logic              pop;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spd_reg   <= SPD_RESET;
            count_reg <= COUNT_RESET;
            vis_reg   <= VIS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_STEPS_PER_DETENT: spd_reg   <= cfg_wdata[3:0];
                CFG_ITEM_COUNT:       count_reg <= cfg_wdata;
                CFG_VISIBLE_LINES:    vis_reg   <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Out-of-range register values fall back to the nearest usable value.
    always_comb begin
        if (spd_reg == 4'd0) begin
            spd_eff = 4'd1;
        end else if (spd_reg > SPD_MAX) begin
            spd_eff = SPD_MAX;
        end else begin
            spd_eff = spd_reg;
        end
        cnt_eff = (count_reg == 8'd0) ? 8'd1 : count_reg;
        vis_eff = (vis_reg == 6'd0) ? 6'd1 : vis_reg;
    end

    // Step decode, detent accumulation and clamped position move.
    always_comb begin
        phase_now  = s_tdata[1:0];
        step       = qmp_step({last_phase_reg, phase_now});
        acc_sum    = 5'(accum_reg) + 5'(step);
        spd_s      = signed'({1'b0, spd_eff});
        pos_inc    = {1'b0, pos_reg} + 9'd1;
        cnt_m1     = cnt_eff - 8'd1;
        accum_next = acc_sum[3:0];
        move       = 2'sd0;
        pos_next   = pos_reg;
        if (acc_sum >= spd_s) begin
            accum_next = 4'(acc_sum - spd_s);
            move       = 2'sd1;
            pos_next   = (pos_inc < {1'b0, cnt_m1}) ? pos_inc[7:0] : cnt_m1;
        end else if (acc_sum <= -spd_s) begin
            accum_next = 4'(acc_sum + spd_s);
            move       = -2'sd1;
            if (pos_reg != 8'd0) begin
                pos_next = pos_reg - 8'd1;
            end
        end
    end

    // Scroll the window just far enough to keep the position in view.
    always_comb begin
        ws_limit = {1'b0, ws_reg} + {3'b0, vis_eff};
        ws_next  = ws_reg;
        if (pos_next < ws_reg) begin
            ws_next = pos_next;
        end else if ({1'b0, pos_next} >= ws_limit) begin
            ws_next = pos_next - ({2'b0, vis_eff} - 8'd1);
        end
        result.position     = pos_next;
        result.window_first = ws_next;
        result.micro_step   = step;
        result.detent_move  = move;
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    // Tracker state advances on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_phase_reg <= PHASE_IDLE;
            accum_reg      <= 4'sd0;
            pos_reg        <= 8'd0;
            ws_reg         <= 8'd0;
        end else if (accept) begin
            last_phase_reg <= phase_now;
            accum_reg      <= accum_next;
            pos_reg        <= pos_next;
            ws_reg         <= ws_next;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload moves without reset.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg};

    // The skid entry is only ever filled behind a held output beat.
    `QMP_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A beat taken while the output is stalled lands in the skid entry.
    `QMP_ASSERT_NEXT(a_stall_to_skid, accept && out_valid_reg && !m_tready, skid_valid_reg)
    // The accumulator never reaches the most negative code, even after the
    // detent size has been lowered.
    `QMP_ASSERT_NOW(a_accum_range, 1'b1, (accum_reg >= -4'sd7))
    // After a sample, the position lies inside the scroll window.
    `QMP_ASSERT_NEXT(a_pos_in_window, accept && !cfg_we,
        (pos_reg >= ws_reg) && ({1'b0, pos_reg} < ws_limit))

endmodule

`default_nettype wire

### tb/tb_quadrature_menu_position.sv
`timescale 1ns / 1ps

// ============================================================================
// tb_quadrature_menu_position
// Self-checking bench for the quadrature menu position tracker. Encoder phase
// samples are streamed in with random gaps while the result stream is stalled
// at random. A behavioral model of the decoder, detent accumulator, clamp and
// scroll window predicts every result beat, and each beat is compared field
// by field. The register settings change between phases, covering the limits
// and the out-of-range values.
// ============================================================================

module tb_quadrature_menu_position;
    import qmp_pkg::*;

    localparam int IDLE_PCT       = 37;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    // Encoder phases in forward rotation order, starting from the idle state.
    localparam logic [1:0] ROTATION [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [1:0] phase_ab, [7:2] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] position, [15:8] window_first,
                             // [17:16] micro_step, [19:18] detent_move, [23:20] zero

    // Register copies and tracker state of the behavioral model.
    logic [3:0]  model_spd;
    logic [7:0]  model_count;
    logic [5:0]  model_vis;
    logic [1:0]  model_prev_phase;
    int          model_accum;
    int          model_pos;
    int          model_win;

    qmp_result_t expected_menu_q[$];
    int          mismatch_count;
    int          quiet_cycles;
    int          hold_left;
    bit          no_idle;
    bit          hold_req;
    logic [1:0]  sent_phase;

    quadrature_menu_position dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Position of a phase pair along the forward rotation.
    function automatic int rotation_index(input logic [1:0] phase);
        case (phase)
            2'b11:   return 0;
            2'b01:   return 1;
            2'b00:   return 2;
            default: return 3;
        endcase
    endfunction

    // Advances the model by one sample and returns the result it should give.
    function automatic qmp_result_t predict_menu_step(input logic [1:0] phase);
        qmp_result_t res;
        int spd;
        int cnt;
        int vis;
        int rot_delta;
        int step;
        int move;
        spd = (model_spd == 0) ? 1 : ((model_spd > 8) ? 8 : int'(model_spd));
        cnt = (model_count == 0) ? 1 : int'(model_count);
        vis = (model_vis == 0) ? 1 : int'(model_vis);

        // One place forward or back along the rotation is a step; a jump of
        // two places or no change gives none.
        rot_delta = (rotation_index(phase) - rotation_index(model_prev_phase)) & 3;
        step = (rot_delta == 1) ? 1 : ((rot_delta == 3) ? -1 : 0);
        model_prev_phase = phase;

        move = 0;
        model_accum += step;
        if (model_accum >= spd) begin
            model_accum -= spd;
            move = 1;
            model_pos = (model_pos + 1 < cnt - 1) ? model_pos + 1 : cnt - 1;
        end else if (model_accum <= -spd) begin
            model_accum += spd;
            move = -1;
            if (model_pos > 0) model_pos--;
        end

        // Scroll the window just far enough to keep the position in view.
        if (model_pos < model_win) begin
            model_win = model_pos;
        end else if (model_pos >= model_win + vis) begin
            model_win = model_pos - (vis - 1);
        end

        res.position     = model_pos[7:0];
        res.window_first = model_win[7:0];
        res.micro_step   = step[1:0];
        res.detent_move  = move[1:0];
        return res;
    endfunction

    // Offers one sample after a random gap and records its prediction on acceptance.
    task automatic send_phase(input logic [1:0] phase);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, phase};
        do @(posedge aclk); while (!s_tready);
        expected_menu_q.push_back(predict_menu_step(phase));
        sent_phase = phase;
    endtask

    // Turns the knob by a number of clean quadrature steps.
    task automatic turn_steps(input int dir, input int count);
        repeat (count) begin
            send_phase(ROTATION[(rotation_index(sent_phase) + dir) & 3]);
        end
    endtask

    // Writes all three registers once the block has drained.
    task automatic set_menu_config(input logic [3:0] spd, input logic [7:0] count,
                                   input logic [5:0] vis);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_menu_q.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_STEPS_PER_DETENT;
        cfg_wdata <= {4'd0, spd};
        @(negedge aclk);
        cfg_addr  <= CFG_ITEM_COUNT;
        cfg_wdata <= count;
        @(negedge aclk);
        cfg_addr  <= CFG_VISIBLE_LINES;
        cfg_wdata <= {2'd0, vis};
        @(negedge aclk);
        cfg_we    <= 1'b0;
        model_spd   = spd;
        model_count = count;
        model_vis   = vis;
    endtask

    // Mostly runs of clean rotation with some bounce, repeats and noise.
    task automatic run_rotation(input int n_items);
        int dir;
        int run_left;
        int pick;
        logic [1:0] phase;
        dir = 1;
        run_left = 0;
        repeat (n_items) begin
            if (run_left == 0) begin
                dir = $urandom_range(1) ? 1 : -1;
                run_left = $urandom_range(60, 1);
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 80) begin
                phase = ROTATION[(rotation_index(sent_phase) + dir) & 3];
            end else if (pick < 88) begin
                phase = sent_phase;
            end else if (pick < 94) begin
                phase = ROTATION[(rotation_index(sent_phase) - dir) & 3];
            end else begin
                phase = 2'($urandom_range(3));
            end
            send_phase(phase);
        end
    endtask

    // Picks a register setting, mostly in range with small counts.
    task automatic pick_random_config();
        logic [3:0] spd;
        logic [7:0] count;
        logic [5:0] vis;
        spd   = ($urandom_range(9) < 8) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
        count = ($urandom_range(3) != 0) ? 8'($urandom_range(40, 1)) : 8'($urandom_range(255));
        vis   = ($urandom_range(3) != 0) ? 6'($urandom_range(12, 1)) : 6'($urandom_range(63));
        set_menu_config(spd, count, vis);
    endtask

    // Every one of the sixteen phase transitions once, at the reset settings.
    task automatic test_step_table();
        logic [1:0] walk [16];
        walk = '{2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3,
                 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};
        foreach (walk[i]) send_phase(walk[i]);
    endtask

    // Zero registers act as one, and a detent at the clamp is still reported.
    task automatic test_zero_registers();
        set_menu_config(4'd0, 8'd0, 6'd0);
        turn_steps(1, 2);
        turn_steps(-1, 1);
    endtask

    // Lowering the item count below the current position.
    task automatic test_count_below_position();
        set_menu_config(4'd1, 8'd20, 6'd32);
        turn_steps(1, 6);
        set_menu_config(4'd1, 8'd3, 6'd1);
        turn_steps(1, 1);
        turn_steps(-1, 2);
    endtask

    // Limits of every register, including values above the usable range.
    task automatic test_register_limits();
        set_menu_config(4'd1, 8'd255, 6'd1);
        run_rotation(100);
        set_menu_config(SPD_MAX, 8'd1, 6'd32);
        run_rotation(100);
        set_menu_config(4'd15, 8'd255, 6'd63);
        run_rotation(100);
        set_menu_config(4'd9, 8'd2, 6'd0);
        run_rotation(100);
    endtask

    // Full rate on both sides.
    task automatic test_full_rate();
        pick_random_config();
        no_idle = 1'b1;
        run_rotation(150);
        no_idle = 1'b0;
    endtask

    // Long receiver stall while samples keep coming, so the input backs up.
    task automatic test_output_stall();
        pick_random_config();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        run_rotation(40);
        wait (!hold_req);
        no_idle = 1'b0;
    endtask

    task automatic test_random_settings(input int n_phases);
        repeat (n_phases) begin
            pick_random_config();
            run_rotation(100);
        end
    endtask

    // Stimulus and end of run.
    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_STEPS_PER_DETENT;
        cfg_wdata = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        mismatch_count   = 0;
        model_spd        = SPD_RESET;
        model_count      = COUNT_RESET;
        model_vis        = VIS_RESET;
        model_prev_phase = PHASE_IDLE;
        sent_phase       = PHASE_IDLE;
        model_accum      = 0;
        model_pos        = 0;
        model_win        = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_step_table();
        test_zero_registers();
        test_count_below_position();
        test_register_limits();
        test_full_rate();
        test_output_stall();
        test_random_settings(8);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_menu_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compares each result beat with the oldest prediction.
    always @(posedge aclk) begin
        qmp_result_t got;
        qmp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = qmp_result_t'(m_tdata[19:0]);
            if (expected_menu_q.size() == 0) begin
                $display("%0t: result beat %h with no sample pending", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_menu_q.pop_front();
                if (got.position !== want.position) begin
                    $display("%0t: position expected %0d got %0d",
                             $time, want.position, got.position);
                    mismatch_count++;
                end
                if (got.window_first !== want.window_first) begin
                    $display("%0t: window_first expected %0d got %0d",
                             $time, want.window_first, got.window_first);
                    mismatch_count++;
                end
                if (got.micro_step !== want.micro_step) begin
                    $display("%0t: micro_step expected %0d got %0d",
                             $time, want.micro_step, got.micro_step);
                    mismatch_count++;
                end
                if (got.detent_move !== want.detent_move) begin
                    $display("%0t: detent_move expected %0d got %0d",
                             $time, want.detent_move, got.detent_move);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when nothing moves on any port for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout, %0d results pending",
                     $time, expected_menu_q.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
